@@ rtl/core/dshot150_frame_transmitter_assert.svh @@
// -----------------------------------------------------------------------------
// dshot150_frame_transmitter_assert.svh
// Assertion macros for the DShot150 frame transmitter. The macros expect clk
// and rst in scope; checks are disabled while rst is high.
// -----------------------------------------------------------------------------
`ifndef DSHOT150_FRAME_TRANSMITTER_ASSERT_SVH
`define DSHOT150_FRAME_TRANSMITTER_ASSERT_SVH

// Check a condition at every clock edge
`define DSHOT_TX_ASSERT_NOW(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a consequent holds in the cycle after its antecedent
`define DSHOT_TX_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/dshot_tx_pkg.sv @@
// -----------------------------------------------------------------------------
// dshot_tx_pkg
// Shared types and constants of the DShot150 frame transmitter.
// -----------------------------------------------------------------------------
`default_nettype none

package dshot_tx_pkg;

  // Field widths
  localparam int unsigned SPEED_W   = 14;
  localparam int unsigned FRAME_W   = 16;
  localparam int unsigned VALUE_W   = 11;
  localparam int unsigned PERIOD_W  = 8;
  localparam int unsigned REPEAT_W  = 10;
  localparam int unsigned GAP_W     = 20;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 20;
  localparam int unsigned BIT_IDX_W = 4;

  // Throttle scaling
  localparam logic [12:0] SPEED_FULL   = 13'd4096;
  localparam logic [10:0] VALUE_SCALE  = 11'd2000;
  localparam logic [11:0] VALUE_OFFSET = 12'd48;
  localparam logic [11:0] VALUE_MAX    = 12'd2047;
  localparam logic [3:0]  NIBBLE_MASK  = 4'hF;

  // Register reset values
  localparam logic [PERIOD_W-1:0] BIT_PERIOD_RST = 8'd51;
  localparam logic [PERIOD_W-1:0] ZERO_HIGH_RST  = 8'd19;
  localparam logic [PERIOD_W-1:0] ONE_HIGH_RST   = 8'd40;
  localparam logic [REPEAT_W-1:0] REPEAT_RST     = 10'd1000;
  localparam logic [GAP_W-1:0]    GAP_RST        = 20'd500;

  // Last bit position of a frame
  localparam logic [BIT_IDX_W-1:0] LAST_BIT = 4'd15;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BIT_PERIOD = 3'd0,
    CFG_ZERO_HIGH  = 3'd1,
    CFG_ONE_HIGH   = 3'd2,
    CFG_REPEAT     = 3'd3,
    CFG_GAP        = 3'd4,
    CFG_TELEMETRY  = 3'd5
  } cfg_reg_t;

  // One result word
  typedef struct packed {
    logic pin_level;
    logic busy_res;
    logic accepted;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/core/dshot_tx_frame_enc.sv @@
// -----------------------------------------------------------------------------
// dshot_tx_frame_enc
// Builds a 16-bit DShot frame from a Q2.12 speed: clamped throttle value,
// telemetry bit and XOR-of-nibbles checksum.
// -----------------------------------------------------------------------------
`default_nettype none

module dshot_tx_frame_enc (
  input  wire logic signed [dshot_tx_pkg::SPEED_W-1:0] speed_q12,
  input  wire logic                                    telemetry,
  output logic [dshot_tx_pkg::FRAME_W-1:0]             frame
);

  logic [12:0] speed_clamped;
  logic [23:0] product;
  logic [11:0] value_raw;
  logic [10:0] value;
  logic [11:0] payload;
  logic [3:0]  checksum;

  // Clamp speed to 0..full scale
  always_comb begin
    if (speed_q12 < 0) begin
      speed_clamped = '0;
    end else if (speed_q12 > $signed({1'b0, dshot_tx_pkg::SPEED_FULL})) begin
      speed_clamped = dshot_tx_pkg::SPEED_FULL;
    end else begin
      speed_clamped = speed_q12[12:0];
    end
  end

  // Scale to throttle value and saturate to 11 bits
  always_comb begin
    product   = 24'(speed_clamped) * 24'(dshot_tx_pkg::VALUE_SCALE);
    value_raw = product[23:12] + dshot_tx_pkg::VALUE_OFFSET;
    if (value_raw > dshot_tx_pkg::VALUE_MAX) begin
      value = dshot_tx_pkg::VALUE_MAX[10:0];
    end else begin
      value = value_raw[10:0];
    end
  end

  // Checksum over value and telemetry bit
  always_comb begin
    payload  = {value, telemetry};
    checksum = (payload[3:0] ^ payload[7:4] ^ payload[11:8]) & dshot_tx_pkg::NIBBLE_MASK;
    frame    = {payload, checksum};
  end

endmodule

`default_nettype wire

@@ rtl/core/dshot150_frame_transmitter.sv @@
// -----------------------------------------------------------------------------
// dshot150_frame_transmitter
// DShot150 frame transmitter: takes throttle commands and tick words, and
// drives one line level per input word with repeated frames and gaps.
// -----------------------------------------------------------------------------
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------
//  in      | in        | in_valid / in_stall | mode, speed_q12
//  out     | out       | out_valid/out_stall | pin_level, busy_res, accepted
//  cfg     | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
//  One word is taken per clock cycle while in_stall is low, with one state
//  update at the input handshake; its result goes to the result register,
//  or to the skid register while that one is stalled. This two-entry output
//  stage keeps the input open while one result is stalled; in_stall rises
//  once both are full. Reset (rst, synchronous) restores register defaults
//  and leaves the block idle. Configuration writes are always ready.
//
`default_nettype none

module dshot150_frame_transmitter (
  input  wire logic                                      clk,
  input  wire logic                                      rst,
  // input words
  input  wire logic                                      in_valid,
  output logic                                           in_stall,
  input  wire logic                                      mode,
  input  wire logic signed [dshot_tx_pkg::SPEED_W-1:0]   speed_q12,
  // result words
  output logic                                           out_valid,
  input  wire logic                                      out_stall,
  output logic                                           pin_level,
  output logic                                           busy_res,
  output logic                                           accepted,
  // configuration writes
  input  wire logic                                      cfg_valid,
  output logic                                           cfg_ready,
  input  wire logic [dshot_tx_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [dshot_tx_pkg::CFG_DAT_W-1:0]        cfg_data
);

  `include "dshot150_frame_transmitter_assert.svh"

  // Configuration registers
  logic [dshot_tx_pkg::PERIOD_W-1:0] bit_period_ticks;
  logic [dshot_tx_pkg::PERIOD_W-1:0] zero_high_ticks;
  logic [dshot_tx_pkg::PERIOD_W-1:0] one_high_ticks;
  logic [dshot_tx_pkg::REPEAT_W-1:0] repeat_count;
  logic [dshot_tx_pkg::GAP_W-1:0]    gap_ticks;
  logic                              telemetry_request;

  // Waveform state
  logic [dshot_tx_pkg::FRAME_W-1:0]   frame_bits, frame_bits_next;
  logic [dshot_tx_pkg::BIT_IDX_W-1:0] bit_index, bit_index_next;
  logic [dshot_tx_pkg::PERIOD_W-1:0]  tick_in_bit, tick_in_bit_next;
  logic [dshot_tx_pkg::REPEAT_W-1:0]  repeats_left, repeats_left_next;
  logic [dshot_tx_pkg::GAP_W-1:0]     gap_left, gap_left_next;
  logic                               in_gap, in_gap_next;

  // Output stage
  dshot_tx_pkg::result_t result, out_word, skid_word;
  logic                  skid_valid;

  logic                              in_accept, out_take;
  logic [dshot_tx_pkg::FRAME_W-1:0]  new_frame;
  logic                              busy, cmd_take;
  logic                              cur_bit;
  logic [dshot_tx_pkg::PERIOD_W-1:0] cur_high, new_high;
  logic                              cur_level;
  logic [dshot_tx_pkg::PERIOD_W:0]   tick_inc;
  logic [dshot_tx_pkg::GAP_W-1:0]    gap_dec;

  assign in_accept = in_valid && !in_stall;
  assign out_take  = out_valid && !out_stall;
  assign in_stall  = skid_valid;
  assign cfg_ready = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_period_ticks  <= dshot_tx_pkg::BIT_PERIOD_RST;
      zero_high_ticks   <= dshot_tx_pkg::ZERO_HIGH_RST;
      one_high_ticks    <= dshot_tx_pkg::ONE_HIGH_RST;
      repeat_count      <= dshot_tx_pkg::REPEAT_RST;
      gap_ticks         <= dshot_tx_pkg::GAP_RST;
      telemetry_request <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dshot_tx_pkg::CFG_BIT_PERIOD: bit_period_ticks  <= cfg_data[dshot_tx_pkg::PERIOD_W-1:0];
        dshot_tx_pkg::CFG_ZERO_HIGH:  zero_high_ticks   <= cfg_data[dshot_tx_pkg::PERIOD_W-1:0];
        dshot_tx_pkg::CFG_ONE_HIGH:   one_high_ticks    <= cfg_data[dshot_tx_pkg::PERIOD_W-1:0];
        dshot_tx_pkg::CFG_REPEAT:     repeat_count      <= cfg_data[dshot_tx_pkg::REPEAT_W-1:0];
        dshot_tx_pkg::CFG_GAP:        gap_ticks         <= cfg_data[dshot_tx_pkg::GAP_W-1:0];
        dshot_tx_pkg::CFG_TELEMETRY:  telemetry_request <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Build the frame for an incoming command
  dshot_tx_frame_enc u_frame_enc (
    .speed_q12 (speed_q12),
    .telemetry (telemetry_request),
    .frame     (new_frame)
  );

  // Current line level
  always_comb begin
    busy      = (repeats_left != '0);
    cur_bit   = frame_bits[dshot_tx_pkg::LAST_BIT - bit_index];
    cur_high  = cur_bit ? one_high_ticks : zero_high_ticks;
    cur_level = busy && !in_gap && (tick_in_bit < cur_high);
    new_high  = new_frame[dshot_tx_pkg::FRAME_W-1] ? one_high_ticks : zero_high_ticks;
    cmd_take  = mode && !busy;
    tick_inc  = {1'b0, tick_in_bit} + 1'b1;
    gap_dec   = gap_left - 1'b1;
  end

  // Next state and result for the word at the input
  always_comb begin
    frame_bits_next   = frame_bits;
    bit_index_next    = bit_index;
    tick_in_bit_next  = tick_in_bit;
    repeats_left_next = repeats_left;
    gap_left_next     = gap_left;
    in_gap_next       = in_gap;
    result.pin_level  = cur_level;
    result.accepted   = 1'b0;
    if (mode) begin
      // Load a command only when idle; level shown is the first of the frame
      if (cmd_take) begin
        frame_bits_next   = new_frame;
        repeats_left_next = repeat_count;
        bit_index_next    = '0;
        tick_in_bit_next  = '0;
        gap_left_next     = '0;
        in_gap_next       = 1'b0;
        result.accepted   = 1'b1;
        result.pin_level  = (repeat_count != '0) && (new_high != '0);
      end
    end else if (busy) begin
      // Advance the waveform by one tick
      if (in_gap) begin
        gap_left_next = gap_dec;
        if (gap_dec == '0) begin
          in_gap_next       = 1'b0;
          bit_index_next    = '0;
          tick_in_bit_next  = '0;
          repeats_left_next = repeats_left - 1'b1;
        end
      end else if (tick_inc < {1'b0, bit_period_ticks}) begin
        tick_in_bit_next = tick_inc[dshot_tx_pkg::PERIOD_W-1:0];
      end else begin
        tick_in_bit_next = '0;
        if (bit_index != dshot_tx_pkg::LAST_BIT) begin
          bit_index_next = bit_index + 1'b1;
        end else if (gap_ticks != '0) begin
          in_gap_next    = 1'b1;
          gap_left_next  = gap_ticks;
          bit_index_next = '0;
        end else begin
          gap_left_next     = '0;
          bit_index_next    = '0;
          repeats_left_next = repeats_left - 1'b1;
        end
      end
    end
    result.busy_res = (repeats_left_next != '0);
  end

  // Update the waveform state on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_bits   <= '0;
      bit_index    <= '0;
      tick_in_bit  <= '0;
      repeats_left <= '0;
      gap_left     <= '0;
      in_gap       <= 1'b0;
    end else if (in_accept) begin
      frame_bits   <= frame_bits_next;
      bit_index    <= bit_index_next;
      tick_in_bit  <= tick_in_bit_next;
      repeats_left <= repeats_left_next;
      gap_left     <= gap_left_next;
      in_gap       <= in_gap_next;
    end
  end

  // Output stage control: fill result register first, spill into skid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_take || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_accept;
      end
    end else if (in_accept) begin
      skid_valid <= 1'b1;
    end
  end

  // Output stage data
  always_ff @(posedge clk) begin
    if (out_take || !out_valid) begin
      if (skid_valid) begin
        out_word <= skid_word;
      end else if (in_accept) begin
        out_word <= result;
      end
    end else if (in_accept) begin
      skid_word <= result;
    end
  end

  assign pin_level = out_word.pin_level;
  assign busy_res  = out_word.busy_res;
  assign accepted  = out_word.accepted;

  // Checks
  `DSHOT_TX_ASSERT_NOW(a_skid_behind_out, !skid_valid || out_valid,
    "skid word held without a result word")
  `DSHOT_TX_ASSERT_NOW(a_gap_only_busy, !in_gap || (repeats_left != '0),
    "gap active while idle")
  `DSHOT_TX_ASSERT_NEXT(a_idle_tick_holds, in_accept && !mode && (repeats_left == '0),
    (repeats_left == '0) && !in_gap, "tick while idle changed state")

endmodule

`default_nettype wire

@@ verif/dshot150_frame_transmitter_checker.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// DShot150 frame transmitter checker
// Watches the input, result and configuration channels of the transmitter,
// keeps its own copy of the registers and of the frame state, predicts the
// result word of every accepted input word and compares each accepted result
// word field by field against the oldest prediction.
// -----------------------------------------------------------------------------

module dshot150_frame_transmitter_checker (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  input  logic                                    in_stall,
  input  logic                                    mode,
  input  logic signed [dshot_tx_pkg::SPEED_W-1:0] speed_q12,
  input  logic                                    out_valid,
  input  logic                                    out_stall,
  input  logic                                    pin_level,
  input  logic                                    busy_res,
  input  logic                                    accepted,
  input  logic                                    cfg_valid,
  input  logic                                    cfg_ready,
  input  logic [dshot_tx_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dshot_tx_pkg::CFG_DAT_W-1:0]      cfg_data,
  output int                                      mismatch_count,
  output int                                      pending,
  output logic                                    busy_pred
);

  // register copy
  logic [dshot_tx_pkg::PERIOD_W-1:0] period_ticks, zero_high, one_high;
  logic [dshot_tx_pkg::REPEAT_W-1:0] repeat_cfg;
  logic [dshot_tx_pkg::GAP_W-1:0]    gap_cfg;
  logic                              tele_cfg;

  // line state
  logic [dshot_tx_pkg::FRAME_W-1:0]   frame_q;
  logic [dshot_tx_pkg::BIT_IDX_W-1:0] bit_pos;
  logic [dshot_tx_pkg::PERIOD_W-1:0]  tick_pos;
  logic [dshot_tx_pkg::REPEAT_W-1:0]  repeats_q;
  logic [dshot_tx_pkg::GAP_W-1:0]     gap_q;
  logic                               gap_phase;

  dshot_tx_pkg::result_t words_due[$];
  int                    words_seen;

  assign busy_pred = (repeats_q != '0);

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  // Build the 16-bit frame from a signed Q2.12 speed
  function automatic logic [dshot_tx_pkg::FRAME_W-1:0] frame_of(
      input logic signed [dshot_tx_pkg::SPEED_W-1:0] speed, input logic tele);
    int          s;
    int unsigned val;
    logic [11:0] v;
    logic [3:0]  csum;
    s = speed;
    if (s < 0) s = 0;
    if (s > int'(dshot_tx_pkg::SPEED_FULL)) s = int'(dshot_tx_pkg::SPEED_FULL);
    val = (int'(s) * int'(dshot_tx_pkg::VALUE_SCALE)) / int'(dshot_tx_pkg::SPEED_FULL)
          + int'(dshot_tx_pkg::VALUE_OFFSET);
    if (val > int'(dshot_tx_pkg::VALUE_MAX)) val = int'(dshot_tx_pkg::VALUE_MAX);
    v = {val[dshot_tx_pkg::VALUE_W-1:0], tele};
    csum = (v[3:0] ^ v[7:4] ^ v[11:8]) & dshot_tx_pkg::NIBBLE_MASK;
    return {val[dshot_tx_pkg::VALUE_W-1:0], tele, csum};
  endfunction

  // Level the line holds in the current state
  function automatic logic line_level_now();
    logic                              high_bit;
    logic [dshot_tx_pkg::PERIOD_W-1:0] high;
    if (repeats_q == '0 || gap_phase) return 1'b0;
    high_bit = frame_q[dshot_tx_pkg::LAST_BIT - bit_pos];
    high = high_bit ? one_high : zero_high;
    return (tick_pos < high);
  endfunction

  function automatic void close_frame();
    gap_phase = 1'b0;
    gap_q     = '0;
    bit_pos   = '0;
    tick_pos  = '0;
    repeats_q = repeats_q - 1'b1;
  endfunction

  // Move the waveform on by one tick
  function automatic void advance_tick();
    if (repeats_q == '0) return;
    if (gap_phase) begin
      gap_q = gap_q - 1'b1;
      if (gap_q == '0) close_frame();
      return;
    end
    if ({1'b0, tick_pos} + 9'd1 < {1'b0, period_ticks}) begin
      tick_pos = tick_pos + 1'b1;
      return;
    end
    tick_pos = '0;
    if (bit_pos != dshot_tx_pkg::LAST_BIT) begin
      bit_pos = bit_pos + 1'b1;
      return;
    end
    if (gap_cfg != '0) begin
      gap_phase = 1'b1;
      gap_q     = gap_cfg;
      bit_pos   = '0;
    end else begin
      close_frame();
    end
  endfunction

  always @(posedge clk) begin : watch
    dshot_tx_pkg::result_t want;
    logic                  lvl;
    logic                  took;
    if (rst) begin
      period_ticks   = dshot_tx_pkg::BIT_PERIOD_RST;
      zero_high      = dshot_tx_pkg::ZERO_HIGH_RST;
      one_high       = dshot_tx_pkg::ONE_HIGH_RST;
      repeat_cfg     = dshot_tx_pkg::REPEAT_RST;
      gap_cfg        = dshot_tx_pkg::GAP_RST;
      tele_cfg       = 1'b0;
      frame_q        = '0;
      bit_pos        = '0;
      tick_pos       = '0;
      repeats_q      = '0;
      gap_q          = '0;
      gap_phase      = 1'b0;
      words_due.delete();
      words_seen     = 0;
      mismatch_count = 0;
    end else begin
      // track register writes
      if (cfg_valid && cfg_ready) begin
        case (dshot_tx_pkg::cfg_reg_t'(cfg_index))
          dshot_tx_pkg::CFG_BIT_PERIOD: period_ticks = cfg_data[dshot_tx_pkg::PERIOD_W-1:0];
          dshot_tx_pkg::CFG_ZERO_HIGH:  zero_high    = cfg_data[dshot_tx_pkg::PERIOD_W-1:0];
          dshot_tx_pkg::CFG_ONE_HIGH:   one_high     = cfg_data[dshot_tx_pkg::PERIOD_W-1:0];
          dshot_tx_pkg::CFG_REPEAT:     repeat_cfg   = cfg_data[dshot_tx_pkg::REPEAT_W-1:0];
          dshot_tx_pkg::CFG_GAP:        gap_cfg      = cfg_data[dshot_tx_pkg::GAP_W-1:0];
          dshot_tx_pkg::CFG_TELEMETRY:  tele_cfg     = cfg_data[0];
          default: ;
        endcase
      end

      // predict the result word of an accepted input word
      if (in_valid && !in_stall) begin
        took = 1'b0;
        if (mode) begin
          if (repeats_q == '0) begin
            frame_q   = frame_of(speed_q12, tele_cfg);
            repeats_q = repeat_cfg;
            bit_pos   = '0;
            tick_pos  = '0;
            gap_q     = '0;
            gap_phase = 1'b0;
            took      = 1'b1;
          end
          lvl = line_level_now();
        end else begin
          lvl = line_level_now();
          advance_tick();
        end
        want.pin_level = lvl;
        want.busy_res  = (repeats_q != '0);
        want.accepted  = took;
        words_due.push_back(want);
      end

      // compare an accepted result word with the oldest prediction
      if (out_valid && !out_stall) begin
        if (words_due.size() == 0) begin
          report_mismatch($sformatf("result word %0d arrived with nothing expected",
                                    words_seen));
        end else begin
          want = words_due.pop_front();
          if (pin_level !== want.pin_level)
            report_mismatch($sformatf("word %0d pin_level got %b want %b",
                                      words_seen, pin_level, want.pin_level));
          if (busy_res !== want.busy_res)
            report_mismatch($sformatf("word %0d busy_res got %b want %b",
                                      words_seen, busy_res, want.busy_res));
          if (accepted !== want.accepted)
            report_mismatch($sformatf("word %0d accepted got %b want %b",
                                      words_seen, accepted, want.accepted));
        end
        words_seen++;
      end
    end
    pending = words_due.size();
  end

endmodule

@@ verif/dshot150_frame_transmitter_tb.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// DShot150 frame transmitter testbench
// Drives throttle commands and tick words through the input channel, writes
// the registers between phases, and stalls the result channel at random.
// A directed part covers speed corners, busy commands, zero repeat, zero
// period, full-period high times and zero gap; random phases follow with
// random small register settings. The checker module judges every word.
// -----------------------------------------------------------------------------

module dshot150_frame_transmitter_tb;

  typedef logic signed [dshot_tx_pkg::SPEED_W-1:0] speed_t;
  typedef logic [dshot_tx_pkg::PERIOD_W-1:0]       ticks_t;
  typedef logic [dshot_tx_pkg::REPEAT_W-1:0]       count_t;
  typedef logic [dshot_tx_pkg::GAP_W-1:0]          gap_t;
  typedef logic [dshot_tx_pkg::CFG_DAT_W-1:0]      cfg_word_t;

  localparam int RANDOM_SETUPS    = 4;
  localparam int WORDS_PER_SETUP  = 80;
  localparam int HOLD_EVERY       = 20000;
  localparam int HOLD_START       = 600;
  localparam int HOLD_LEN         = 100;

  logic                                 clk = 1'b0;
  logic                                 rst = 1'b1;
  logic                                 in_valid = 1'b0;
  logic                                 in_stall;
  logic                                 mode = 1'b0;
  speed_t                               speed_q12 = '0;
  logic                                 out_valid;
  logic                                 out_stall = 1'b0;
  logic                                 pin_level;
  logic                                 busy_res;
  logic                                 accepted;
  logic                                 cfg_valid = 1'b0;
  logic                                 cfg_ready;
  logic [dshot_tx_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
  cfg_word_t                            cfg_data = '0;

  int   mismatch_count;
  int   pending_words;
  logic busy_pred;
  int   burst_left = 0;

  always #6 clk = ~clk;

  dshot150_frame_transmitter DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .mode      (mode),
    .speed_q12 (speed_q12),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .pin_level (pin_level),
    .busy_res  (busy_res),
    .accepted  (accepted),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  dshot150_frame_transmitter_checker line_check (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .mode           (mode),
    .speed_q12      (speed_q12),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .pin_level      (pin_level),
    .busy_res       (busy_res),
    .accepted       (accepted),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .pending        (pending_words),
    .busy_pred      (busy_pred)
  );

  // Speed mix: corners, the useful 0..1 range, and anything 14 bits hold
  function automatic speed_t rand_speed();
    case ($urandom_range(0, 5))
      0: begin
        case ($urandom_range(0, 7))
          0:       return 14'h2000;
          1:       return 14'h3FFF;
          2:       return 14'd0;
          3:       return 14'd1;
          4:       return 14'd4095;
          5:       return 14'd4096;
          6:       return 14'd4097;
          default: return 14'h1FFF;
        endcase
      end
      1, 2:    return speed_t'($urandom_range(0, 4096));
      default: return speed_t'($urandom);
    endcase
  endfunction

  // Register writes leave cfg_valid high; close a batch with end_writes
  task automatic write_reg(input dshot_tx_pkg::cfg_reg_t idx, input cfg_word_t val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic program_all(input ticks_t period, input ticks_t zero,
                             input ticks_t one, input count_t rep,
                             input gap_t gap, input logic tele);
    write_reg(dshot_tx_pkg::CFG_BIT_PERIOD, cfg_word_t'(period));
    write_reg(dshot_tx_pkg::CFG_ZERO_HIGH, cfg_word_t'(zero));
    write_reg(dshot_tx_pkg::CFG_ONE_HIGH, cfg_word_t'(one));
    write_reg(dshot_tx_pkg::CFG_REPEAT, cfg_word_t'(rep));
    write_reg(dshot_tx_pkg::CFG_GAP, cfg_word_t'(gap));
    write_reg(dshot_tx_pkg::CFG_TELEMETRY, cfg_word_t'(tele));
    end_writes();
  endtask

  // Offer a word from a falling edge and hold it until taken
  task automatic drive_word(input logic m, input speed_t s);
    in_valid  <= 1'b1;
    mode      <= m;
    speed_q12 <= s;
    do @(posedge clk); while (in_stall);
  endtask

  // Sender bursts: count down the burst, then start a new one; a short burst follows a random idle gap
  task automatic pace();
    int gap;
    gap = 0;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      if ($urandom_range(0, 3) == 0) begin
        burst_left = $urandom_range(80, 200);
      end else begin
        burst_left = $urandom_range(1, 30);
        gap = $urandom_range(1, 10);
      end
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  task automatic send(input logic m, input speed_t s);
    @(negedge clk);
    drive_word(m, s);
    pace();
  endtask

  // Tick until the frames run out, then wait for every result word
  task automatic settle();
    bit done;
    done = 1'b0;
    while (!done) begin
      @(negedge clk);
      if (!busy_pred) begin
        in_valid <= 1'b0;
        done = 1'b1;
      end else begin
        drive_word(1'b0, rand_speed());
        pace();
      end
    end
    while (pending_words != 0) @(negedge clk);
  endtask

  task automatic random_setup();
    ticks_t period;
    count_t rep;
    period = ($urandom_range(0, 9) == 0) ? ticks_t'($urandom_range(0, 1))
                                         : ticks_t'($urandom_range(2, 8));
    rep = ($urandom_range(0, 7) == 0) ? '0 : count_t'($urandom_range(1, 3));
    program_all(period, ticks_t'($urandom_range(1, period + 1)),
                ticks_t'($urandom_range(1, period + 1)), rep,
                gap_t'($urandom_range(0, 6)), 1'($urandom_range(0, 1)));
  endtask

  // Result side: stall patterns in segments, plus a long hold now and then
  initial begin : result_side
    int seg_len;
    int style;
    int cyc;
    cyc = 0;
    forever begin
      seg_len = $urandom_range(10, 150);
      style = $urandom_range(0, 3);
      repeat (seg_len) begin
        @(negedge clk);
        cyc++;
        if ((cyc % HOLD_EVERY) >= HOLD_START && (cyc % HOLD_EVERY) < HOLD_START + HOLD_LEN) begin
          out_stall <= 1'b1;
        end else begin
          case (style)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            2:       out_stall <= ($urandom_range(0, 1) == 0);
            default: out_stall <= ($urandom_range(0, 3) != 0);
          endcase
        end
      end
    end
  end

  // Stimulus and verdict
  initial begin : stimulus
    speed_t corners[6];
    logic   m;
    corners = '{14'h1FFF, 14'd0, 14'd1, 14'h3FFF, 14'd4095, 14'd2048};

    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // Reset bit timing with a single frame: idle ticks, full throttle, busy command
    write_reg(dshot_tx_pkg::CFG_REPEAT, 20'd1);
    write_reg(dshot_tx_pkg::CFG_GAP, 20'd4);
    end_writes();
    send(1'b0, rand_speed());
    send(1'b0, rand_speed());
    send(1'b1, 14'd4096);
    send(1'b1, 14'h2000);
    settle();

    // Short bits, zero gap, telemetry on, one bit high for the whole period
    program_all(8'd2, 8'd1, 8'd2, 10'd1, 20'd0, 1'b1);
    foreach (corners[i]) begin
      send(1'b1, corners[i]);
      settle();
    end

    // Zero repeat takes the command and sends nothing; zero period
    program_all(8'd0, 8'd254, 8'd1, 10'd0, 20'hFFFFF, 1'b0);
    send(1'b1, 14'd1000);
    send(1'b0, rand_speed());
    send(1'b1, 14'd2000);
    send(1'b0, rand_speed());
    settle();
    write_reg(dshot_tx_pkg::CFG_REPEAT, 20'd2);
    write_reg(dshot_tx_pkg::CFG_GAP, 20'd3);
    end_writes();
    send(1'b1, 14'd3000);
    settle();

    // Longer bit period with wide and narrow high times
    program_all(8'd12, 8'd1, 8'd11, 10'd1, 20'd4, 1'b1);
    send(1'b1, rand_speed());
    settle();

    // Several repeats of one-tick bits
    program_all(8'd0, 8'd1, 8'd1, 10'd8, 20'd1, 1'b0);
    send(1'b1, rand_speed());
    settle();

    // Random phases: mostly ticks, commands more likely while idle
    repeat (RANDOM_SETUPS) begin
      random_setup();
      repeat (WORDS_PER_SETUP) begin
        @(negedge clk);
        m = busy_pred ? ($urandom_range(0, 15) == 0) : ($urandom_range(0, 2) == 0);
        drive_word(m, rand_speed());
        pace();
      end
      settle();
    end

    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && pending_words == 0) begin
      $display("dshot150_frame_transmitter regression: pass");
    end else begin
      $display("dshot150_frame_transmitter regression: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #3000000;
    $display("dshot150_frame_transmitter regression: fail");
    $finish;
  end

endmodule
